// ===== sv/lds_pkg.sv =====
package lds_pkg;

   localparam int MAX_REQUESTS_DEF = 16;
   localparam int CYL_W            = 16;
   localparam int TOTAL_W          = 22;
   localparam int CSR_IDX_W        = 1;

   localparam logic [CSR_IDX_W-1:0] CSR_START_HEAD = 1'b0;
   localparam logic [CSR_IDX_W-1:0] CSR_SWEEP_UP   = 1'b1;

   typedef struct packed {
      logic [CYL_W-1:0] request_cylinder;
      logic             batch_end;
   } req_type;

   typedef struct packed {
      logic [CYL_W-1:0]   served_cylinder;
      logic [CYL_W-1:0]   step_seek;
      logic [TOTAL_W-1:0] total_seek;
      logic               final_result;
   } rsp_type;

endpackage

// ===== sv/lds_ram.sv =====
module lds_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 16,
   localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic             clock,
   input  logic             wr_en,
   input  logic [AW-1:0]    wr_addr,
   input  logic [WIDTH-1:0] wr_data,
   input  logic             rd_en,
   input  logic [AW-1:0]    rd_addr,
   output logic [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== sv/look_disk_scheduler_top.sv =====
// Channel   Ports                                 Direction  Handshake
// request   start, busy, req_data                 in         start & !busy
// result    rsp_valid, rsp_data                   out        rsp_valid, one cycle
// csr       csr_valid, csr_ready, csr_index,      in         csr_valid & csr_ready
//           csr_wdata
//
// A request that does not end a batch is stored in the request RAM while it has room. The
// end of a batch of n > 1 requests starts an in-place exchange sort on the request RAM
// through its single read port, then a scan for the split, and then each result is read
// from the RAM and put out in turn. Synchronous reset clears control state only; the
// RAM holds no reset. Results cannot be held off and leave the cycle they appear.
module look_disk_scheduler_top
   import lds_pkg::*;
#(
   parameter int MAX_REQUESTS = MAX_REQUESTS_DEF
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 start,
   output logic                 busy,
   input  req_type              req_data,
   output logic                 rsp_valid,
   output rsp_type              rsp_data,
   input  logic                 csr_valid,
   output logic                 csr_ready,
   input  logic [CSR_IDX_W-1:0] csr_index,
   input  logic [CYL_W-1:0]     csr_wdata
);

   localparam int CW = $clog2(MAX_REQUESTS + 1);
   localparam int AW = (MAX_REQUESTS > 1) ? $clog2(MAX_REQUESTS) : 1;

   typedef enum logic [3:0] {
      S_IDLE,
      S_SORT_A,
      S_SORT_B0,
      S_SORT_B,
      S_SORT_WA,
      S_FIND_RD,
      S_FIND_CMP,
      S_EMIT_RD,
      S_EMIT_OUT
   } state_type;

   state_type          state_ff, state_in;
   logic [CW-1:0]      count_ff, count_in;
   logic [CW-1:0]      n_ff, n_in;
   logic [CW-1:0]      a_ff, a_in;
   logic [CW-1:0]      b_ff, b_in;
   logic [CW-1:0]      k_ff, k_in;
   logic [CW-1:0]      split_ff, split_in;
   logic [CYL_W-1:0]   cur_ff, cur_in;
   logic [CYL_W-1:0]   head_ff, head_in;
   logic [TOTAL_W-1:0] total_ff, total_in;
   logic               up_ff, up_in;
   logic [CYL_W-1:0]   start_head_ff;
   logic               sweep_up_ff;
   logic               rsp_valid_ff, rsp_valid_in;
   rsp_type            rsp_ff, rsp_in;

   logic               wr_en;
   logic [AW-1:0]      wr_addr;
   logic [CYL_W-1:0]   wr_data;
   logic               rd_en;
   logic [AW-1:0]      rd_addr;
   logic [CYL_W-1:0]   rd_data;

   logic [CW-1:0]      cnt_new;
   logic [CW-1:0]      emit_idx;
   logic [CYL_W-1:0]   step;

   lds_ram #(
      .WIDTH (CYL_W),
      .DEPTH (MAX_REQUESTS)
   ) u_store (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   assign busy      = (state_ff != S_IDLE);
   assign csr_ready = 1'b1;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   always_comb begin
      if (up_ff) begin
         if (k_ff < n_ff - split_ff) begin
            emit_idx = split_ff + k_ff;
         end else begin
            emit_idx = n_ff - CW'(1) - k_ff;
         end
      end else begin
         if (k_ff < split_ff) begin
            emit_idx = split_ff - CW'(1) - k_ff;
         end else begin
            emit_idx = k_ff;
         end
      end
      step = (rd_data >= head_ff) ? (rd_data - head_ff) : (head_ff - rd_data);
   end

   always_comb begin
      state_in     = state_ff;
      count_in     = count_ff;
      n_in         = n_ff;
      a_in         = a_ff;
      b_in         = b_ff;
      k_in         = k_ff;
      split_in     = split_ff;
      cur_in       = cur_ff;
      head_in      = head_ff;
      total_in     = total_ff;
      up_in        = up_ff;
      rsp_valid_in = 1'b0;
      rsp_in       = rsp_ff;
      wr_en        = 1'b0;
      wr_addr      = '0;
      wr_data      = cur_ff;
      rd_en        = 1'b0;
      rd_addr      = '0;
      cnt_new      = count_ff;

      unique case (state_ff)
         S_IDLE: begin
            if (start) begin
               if (count_ff < CW'(MAX_REQUESTS)) begin
                  wr_en   = 1'b1;
                  wr_addr = count_ff[AW-1:0];
                  wr_data = req_data.request_cylinder;
                  cnt_new = count_ff + CW'(1);
               end
               count_in = cnt_new;
               if (req_data.batch_end) begin
                  n_in    = cnt_new;
                  head_in = start_head_ff;
                  up_in   = sweep_up_ff;
                  a_in    = '0;
                  k_in    = '0;
                  state_in = (cnt_new == CW'(1)) ? S_FIND_RD : S_SORT_A;
               end
            end
         end
         S_SORT_A: begin
            rd_en    = 1'b1;
            rd_addr  = a_ff[AW-1:0];
            b_in     = a_ff + CW'(1);
            state_in = S_SORT_B0;
         end
         S_SORT_B0: begin
            cur_in   = rd_data;
            rd_en    = 1'b1;
            rd_addr  = b_ff[AW-1:0];
            state_in = S_SORT_B;
         end
         S_SORT_B: begin
            if (rd_data < cur_ff) begin
               wr_en   = 1'b1;
               wr_addr = b_ff[AW-1:0];
               wr_data = cur_ff;
               cur_in  = rd_data;
            end
            if (b_ff == n_ff - CW'(1)) begin
               state_in = S_SORT_WA;
            end else begin
               b_in    = b_ff + CW'(1);
               rd_en   = 1'b1;
               rd_addr = b_in[AW-1:0];
            end
         end
         S_SORT_WA: begin
            wr_en   = 1'b1;
            wr_addr = a_ff[AW-1:0];
            wr_data = cur_ff;
            if (a_ff + CW'(2) == n_ff) begin
               k_in     = '0;
               state_in = S_FIND_RD;
            end else begin
               a_in     = a_ff + CW'(1);
               state_in = S_SORT_A;
            end
         end
         S_FIND_RD: begin
            rd_en    = 1'b1;
            rd_addr  = k_ff[AW-1:0];
            state_in = S_FIND_CMP;
         end
         S_FIND_CMP: begin
            if (rd_data >= head_ff) begin
               split_in = k_ff;
               k_in     = '0;
               total_in = '0;
               state_in = S_EMIT_RD;
            end else if (k_ff == n_ff - CW'(1)) begin
               split_in = n_ff;
               k_in     = '0;
               total_in = '0;
               state_in = S_EMIT_RD;
            end else begin
               k_in     = k_ff + CW'(1);
               state_in = S_FIND_RD;
            end
         end
         S_EMIT_RD: begin
            rd_en    = 1'b1;
            rd_addr  = emit_idx[AW-1:0];
            state_in = S_EMIT_OUT;
         end
         S_EMIT_OUT: begin
            total_in               = total_ff + TOTAL_W'(step);
            head_in                = rd_data;
            rsp_valid_in           = 1'b1;
            rsp_in.served_cylinder = rd_data;
            rsp_in.step_seek       = step;
            rsp_in.total_seek      = total_in;
            rsp_in.final_result    = (k_ff == n_ff - CW'(1));
            if (k_ff == n_ff - CW'(1)) begin
               count_in = '0;
               state_in = S_IDLE;
            end else begin
               k_in     = k_ff + CW'(1);
               state_in = S_EMIT_RD;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= S_IDLE;
         count_ff      <= '0;
         rsp_valid_ff  <= 1'b0;
         start_head_ff <= '0;
         sweep_up_ff   <= 1'b1;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_valid && csr_ready) begin
            unique case (csr_index)
               CSR_START_HEAD: start_head_ff <= csr_wdata;
               CSR_SWEEP_UP:   sweep_up_ff   <= csr_wdata[0];
               default: begin
               end
            endcase
         end
      end
      n_ff     <= n_in;
      a_ff     <= a_in;
      b_ff     <= b_in;
      k_ff     <= k_in;
      split_ff <= split_in;
      cur_ff   <= cur_in;
      head_ff  <= head_in;
      total_ff <= total_in;
      up_ff    <= up_in;
      rsp_ff   <= rsp_in;
   end

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CW'(MAX_REQUESTS))
      else $error("request count beyond store depth");

   a_rsp_source: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> $past(state_ff == S_EMIT_OUT))
      else $error("result strobe without an emit cycle");

   a_final_idle: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.final_result |-> state_ff == S_IDLE && count_ff == '0)
      else $error("batch not closed on final result");

   a_sort_order: assert property (@(posedge clock) disable iff (reset)
      state_ff == S_SORT_B |-> b_ff > a_ff && b_ff < n_ff)
      else $error("sort inner index out of range");

endmodule

// ===== tb/tb.sv =====
`timescale 1ns / 100ps

import lds_pkg::*;

class look_order_board;
   localparam int DEPTH = MAX_REQUESTS_DEF;

   logic [CYL_W-1:0] pending_cylinders[$];
   rsp_type          due_results[$];
   logic [CYL_W-1:0] head_position;
   logic             sweep_up_first;
   int               mismatch_count;

   function new();
      head_position  = '0;
      sweep_up_first = 1'b1;
      mismatch_count = 0;
   endfunction

   function void write_register(logic [CSR_IDX_W-1:0] idx, logic [CYL_W-1:0] value);
      case (idx)
         CSR_START_HEAD: begin
            head_position = value;
         end
         CSR_SWEEP_UP: begin
            sweep_up_first = value[0];
         end
         default: begin
         end
      endcase
   endfunction

   function void note_request(req_type r);
      logic [CYL_W-1:0]   sorted_cyl[$];
      logic [CYL_W-1:0]   service[$];
      logic [CYL_W-1:0]   arm;
      logic [CYL_W-1:0]   step;
      logic [TOTAL_W-1:0] total;
      rsp_type            res;
      int                 split;
      if (pending_cylinders.size() < DEPTH) begin
         pending_cylinders.push_back(r.request_cylinder);
      end
      if (!r.batch_end) begin
         return;
      end
      sorted_cyl = pending_cylinders;
      sorted_cyl.sort();
      split = sorted_cyl.size();
      for (int k = 0; k < sorted_cyl.size(); k++) begin
         if (sorted_cyl[k] >= head_position) begin
            split = k;
            break;
         end
      end
      if (sweep_up_first) begin
         for (int k = split; k < sorted_cyl.size(); k++) service.push_back(sorted_cyl[k]);
         for (int k = split - 1; k >= 0; k--) service.push_back(sorted_cyl[k]);
      end else begin
         for (int k = split - 1; k >= 0; k--) service.push_back(sorted_cyl[k]);
         for (int k = split; k < sorted_cyl.size(); k++) service.push_back(sorted_cyl[k]);
      end
      arm   = head_position;
      total = '0;
      foreach (service[k]) begin
         step  = (service[k] >= arm) ? service[k] - arm : arm - service[k];
         total = total + TOTAL_W'(step);
         res.served_cylinder = service[k];
         res.step_seek       = step;
         res.total_seek      = total;
         res.final_result    = (k == service.size() - 1);
         due_results.push_back(res);
         arm = service[k];
      end
      pending_cylinders.delete();
   endfunction

   function void report_field(string name, logic [TOTAL_W-1:0] want, logic [TOTAL_W-1:0] got);
      if (want !== got) begin
         $display("%0t: %s mismatch, expected %h actual %h", $time, name, want, got);
         mismatch_count++;
      end
   endfunction

   function void check_result(rsp_type got);
      rsp_type want;
      if (due_results.size() == 0) begin
         $display("%0t: unexpected result, expected none actual %h", $time, got);
         mismatch_count++;
         return;
      end
      want = due_results.pop_front();
      report_field("served_cylinder", TOTAL_W'(want.served_cylinder),
                   TOTAL_W'(got.served_cylinder));
      report_field("step_seek", TOTAL_W'(want.step_seek), TOTAL_W'(got.step_seek));
      report_field("total_seek", want.total_seek, got.total_seek);
      report_field("final_result", TOTAL_W'(want.final_result), TOTAL_W'(got.final_result));
   endfunction
endclass

module tb;
   typedef logic [CYL_W-1:0] cyl_list_type[$];

   logic                 clock = 1'b0;
   logic                 reset = 1'b1;
   logic                 start = 1'b0;
   logic                 busy;
   req_type              req_data = '0;
   logic                 rsp_valid;
   rsp_type              rsp_data;
   logic                 csr_valid = 1'b0;
   logic                 csr_ready;
   logic [CSR_IDX_W-1:0] csr_index = '0;
   logic [CYL_W-1:0]     csr_wdata = '0;

   look_order_board board;
   bit              calm;
   int              sent;

   look_disk_scheduler_top i_dut (
      .clock     (clock),
      .reset     (reset),
      .start     (start),
      .busy      (busy),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_data  (rsp_data),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   always @(posedge clock) begin
      if (!reset && rsp_valid === 1'b1) begin
         board.check_result(rsp_data);
      end
   end

   task automatic send_request(logic [CYL_W-1:0] cyl, bit last);
      req_type r;
      r.request_cylinder = cyl;
      r.batch_end        = last;
      if (!calm) begin
         while ($urandom_range(99) < 13) begin
            start <= 1'b0;
            @(posedge clock);
         end
      end
      start    <= 1'b1;
      req_data <= r;
      do @(posedge clock); while (busy !== 1'b0);
      board.note_request(r);
      sent++;
   endtask

   task automatic run_batch(cyl_list_type cyls);
      foreach (cyls[k]) send_request(cyls[k], k == cyls.size() - 1);
   endtask

   // hold off until every result is out and the block has settled
   task automatic drain();
      while (board.due_results.size() != 0) @(posedge clock);
      repeat (8) @(posedge clock);
   endtask

   task automatic write_csr(logic [CSR_IDX_W-1:0] idx, logic [CYL_W-1:0] value);
      start <= 1'b0;
      drain();
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_wdata <= value;
      do @(posedge clock); while (csr_ready !== 1'b1);
      csr_valid <= 1'b0;
      board.write_register(idx, value);
   endtask

   initial begin
      cyl_list_type     cyls;
      logic [CYL_W-1:0] base;
      int               len;
      int               pick;
      int               batch;
      bit               clustered;
      board = new();
      calm  = 1'b0;
      sent  = 0;
      repeat (4) @(posedge clock);
      reset <= 1'b0;

      run_batch('{16'hFFFF});
      run_batch('{16'd5, 16'd0, 16'd5});
      write_csr(CSR_START_HEAD, 16'hFFFF);
      write_csr(CSR_SWEEP_UP, 16'h0000);
      run_batch('{16'h0000, 16'hFFFF, 16'h1234});
      write_csr(CSR_START_HEAD, 16'h8000);
      write_csr(CSR_SWEEP_UP, 16'h0001);
      run_batch('{16'h8000, 16'h7FFF, 16'h8001, 16'h0001});
      run_batch('{16'd1, 16'd2, 16'd3});
      write_csr(CSR_START_HEAD, 16'h0000);
      write_csr(CSR_SWEEP_UP, 16'hFFFE);
      run_batch('{16'd7, 16'd3});

      batch = 0;
      while (sent < 100) begin
         calm = (batch >= 3 && batch <= 6);
         if ($urandom_range(2) == 0) begin
            pick = $urandom_range(3);
            write_csr(CSR_START_HEAD, (pick == 0) ? 16'h0000 :
                                      (pick == 1) ? 16'hFFFF : 16'($urandom));
         end
         if ($urandom_range(2) == 0) begin
            write_csr(CSR_SWEEP_UP, 16'($urandom));
         end
         pick = $urandom_range(99);
         if (pick < 10) begin
            len = $urandom_range(17, 20);
         end else if (pick < 20) begin
            len = MAX_REQUESTS_DEF;
         end else begin
            len = $urandom_range(1, 8);
         end
         clustered = ($urandom_range(2) == 0);
         base      = 16'($urandom);
         cyls.delete();
         repeat (len) begin
            cyls.push_back(clustered ? 16'(base + $urandom_range(0, 7)) : 16'($urandom));
         end
         run_batch(cyls);
         batch++;
      end

      calm = 1'b0;
      start <= 1'b0;
      while (board.due_results.size() != 0) @(posedge clock);
      repeat (20) @(posedge clock);
      if (board.mismatch_count == 0) begin
         $display("CHECK OK");
      end else begin
         $display("CHECK FAILED");
      end
      $finish;
   end

   initial begin
      #400000;
      $display("CHECK FAILED");
      $finish;
   end
endmodule
